// ===== design/lffr_pkg.sv =====
// Package for the LED fade/flash ramp: field widths, register indexes,
// sequencer state type and step limits. No dependencies.
package lffr_pkg;

  localparam int LEVEL_W    = 8;
  localparam int PERIOD_W   = 16;
  localparam int PROD_W     = LEVEL_W + PERIOD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W      = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FLASH_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_TIME      = 3'd4;

  // last count of each serial phase
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(LEVEL_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

  localparam logic [LEVEL_W-1:0] STEP_FLOOR = 8'd1;
  localparam logic [LEVEL_W-1:0] STEP_CEIL  = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== design/led_fade_flash_ramp.sv =====
// LED fade/flash ramp: top level, holds the whole datapath and sequencer.
// Depends on lffr_pkg.
//
// Each input transfer is one refresh tick. The tick optionally loads a new
// target (in_tuser = load_target, in_tdata = target_level), turns the target
// at the min/max bounds in flash mode, and then moves the brightness toward
// the target by step = (max - min) * refresh_period / fade_time, clamped to
// 1..255 (max below min gives zero span, fade_time 0 acts as 1). A step that
// would pass the target lands on it. Each tick yields one output transfer with
// the new duty in out_tdata and a changed flag in out_tuser. The step is
// computed bit-serially, between an accept state and an apply state: a
// shift-add multiply (one span bit a cycle), then a restoring division (one
// quotient bit a cycle). A new tick is taken only after the previous one has
// been applied. A finished result waits in the output register while the
// next tick is accepted; the apply cycle holds while that result is still
// unclaimed. Configuration writes (cfg_valid/cfg_index/cfg_data) are always
// taken; unknown indexes are dropped. Write them only while idle.
module led_fade_flash_ramp (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lffr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lffr_pkg::CFG_DATA_W-1:0]     cfg_data,
  // tick input
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lffr_pkg::LEVEL_W-1:0]        in_tdata,   // [7:0] target_level
  input  logic                                in_tuser,   // [0] load_target
  // result output
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lffr_pkg::LEVEL_W-1:0]        out_tdata,  // [7:0] duty
  output logic                                out_tuser   // [0] duty_changed
);
  import lffr_pkg::*;

  // configuration registers
  logic                  flash_mode_r;
  logic [LEVEL_W-1:0]    min_level_r;
  logic [LEVEL_W-1:0]    max_level_r;
  logic [PERIOD_W-1:0]   refresh_period_r;
  logic [PERIOD_W-1:0]   fade_time_r;

  // sequencer and datapath
  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [PROD_W-1:0]     acc_r, acc_nxt;     // product, then dividend/quotient
  logic [PERIOD_W-1:0]   rem_r, rem_nxt;     // division remainder
  logic [LEVEL_W-1:0]    goal_r, goal_nxt;
  logic [LEVEL_W-1:0]    cur_r, cur_nxt;     // current level; also the applied level
  logic                  out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]    out_duty_r, out_duty_nxt;
  logic                  out_chg_r, out_chg_nxt;

  // combinational helpers
  logic [LEVEL_W-1:0]    span;
  logic [PERIOD_W-1:0]   divisor;
  logic [LEVEL_W-1:0]    goal_load;
  logic [PERIOD_W:0]     mul_sum;
  logic [PERIOD_W:0]     trial;
  logic [PERIOD_W:0]     trial_diff;
  logic                  q_bit;
  logic [LEVEL_W-1:0]    step;
  logic [LEVEL_W:0]      level_gap;
  logic [LEVEL_W-1:0]    moved;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_duty_r;
  assign out_tuser  = out_chg_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_mode_r     <= 1'b0;
      min_level_r      <= 8'd0;
      max_level_r      <= 8'd255;
      refresh_period_r <= 16'd20;
      fade_time_r      <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FLASH_MODE:     flash_mode_r     <= cfg_data[0];
        REG_MIN_LEVEL:      min_level_r      <= cfg_data[LEVEL_W-1:0];
        REG_MAX_LEVEL:      max_level_r      <= cfg_data[LEVEL_W-1:0];
        REG_REFRESH_PERIOD: refresh_period_r <= cfg_data[PERIOD_W-1:0];
        REG_FADE_TIME:      fade_time_r      <= cfg_data[PERIOD_W-1:0];
        default:            ;  // drop writes to unknown indexes
      endcase
    end
  end

  // span and divisor follow the config directly; the user must keep config stable during a tick (not enforced here)
  assign span    = (max_level_r > min_level_r) ? (max_level_r - min_level_r) : '0;
  assign divisor = (fade_time_r == '0) ? PERIOD_W'(1) : fade_time_r;

  // load the target, then turn it at the bounds in flash mode
  always_comb begin
    goal_load = in_tuser ? in_tdata : goal_r;
    if (flash_mode_r) begin
      if (cur_r <= min_level_r) begin
        goal_load = max_level_r;
      end else if (cur_r >= max_level_r) begin
        goal_load = min_level_r;
      end
    end
  end

  // one multiply step: add refresh_period into the upper part when the
  // low span bit is set, then shift the whole accumulator right
  assign mul_sum = {1'b0, acc_r[PROD_W-1:LEVEL_W]}
                 + (acc_r[0] ? {1'b0, refresh_period_r} : '0);

  // one restoring division step: shift in the next dividend bit, try subtract
  assign trial      = {rem_r, acc_r[PROD_W-1]};
  assign trial_diff = trial - {1'b0, divisor};
  assign q_bit      = (trial >= {1'b0, divisor});

  // clamp the quotient to 1..255
  always_comb begin
    if (acc_r[PROD_W-1:LEVEL_W] != '0) begin
      step = STEP_CEIL;
    end else if (acc_r[LEVEL_W-1:0] < STEP_FLOOR) begin
      step = STEP_FLOOR;
    end else begin
      step = acc_r[LEVEL_W-1:0];
    end
  end

  // move toward the goal, landing on it when the step would pass it
  always_comb begin
    level_gap = '0;
    moved     = cur_r;
    if (cur_r < goal_r) begin
      level_gap = {1'b0, goal_r} - {1'b0, cur_r};
      moved     = (level_gap <= {1'b0, step}) ? goal_r : cur_r + step;
    end else if (cur_r > goal_r) begin
      level_gap = {1'b0, cur_r} - {1'b0, goal_r};
      moved     = (level_gap <= {1'b0, step}) ? goal_r : cur_r - step;
    end
  end

  // sequencer: accept, multiply, divide, apply
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    goal_nxt      = goal_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    out_duty_nxt  = out_duty_r;
    out_chg_nxt   = out_chg_r;
    in_tready     = 1'b0;

    // retire the waiting result on its transfer
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          goal_nxt  = goal_load;
          acc_nxt   = {{PERIOD_W{1'b0}}, span};
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_nxt = {mul_sum, acc_r[LEVEL_W-1:1]};
        if (cnt_r == MUL_LAST) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DIV: begin
        rem_nxt = q_bit ? trial_diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
        acc_nxt = {acc_r[PROD_W-2:0], q_bit};
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cur_nxt       = moved;
          out_duty_nxt  = moved;
          out_chg_nxt   = (moved != cur_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      goal_r      <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      goal_r      <= goal_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    out_duty_r <= out_duty_nxt;
    out_chg_r  <= out_chg_nxt;
  end

endmodule

// ===== test/led_fade_flash_ramp_test.sv =====
// Self-checking testbench for led_fade_flash_ramp: a queue-fed stream driver,
// a result monitor with its own brightness ramp predictor, and config phases.
// Depends on lffr_pkg and the led_fade_flash_ramp RTL.
module led_fade_flash_ramp_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lffr_pkg::*;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES      = 40;
  localparam int RANDOM_TICKS     = 2000;

  typedef struct packed {
    logic               load;
    logic [LEVEL_W-1:0] level;
  } tick_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] duty;
    logic               changed;
  } duty_result_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [LEVEL_W-1:0]    in_tdata = '0;   // [7:0] target_level
  logic                  in_tuser = 1'b0; // [0] load_target
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [LEVEL_W-1:0]    out_tdata;       // [7:0] duty
  logic                  out_tuser;       // [0] duty_changed

  led_fade_flash_ramp dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Predictor copy of the registers, reset values.
  logic                cfg_flash  = 1'b0;
  logic [LEVEL_W-1:0]  cfg_min    = 8'd0;
  logic [LEVEL_W-1:0]  cfg_max    = 8'd255;
  logic [PERIOD_W-1:0] cfg_period = 16'd20;
  logic [PERIOD_W-1:0] cfg_fade   = 16'd1000;

  // Predictor copy of the brightness state.
  logic [LEVEL_W-1:0] cur_level     = '0;
  logic [LEVEL_W-1:0] applied_level = '0;
  logic [LEVEL_W-1:0] goal_level    = '0;

  tick_t        tick_queue[$];
  duty_result_t duty_expected[$];
  tick_t        offered;
  int           errors = 0;
  int           ticks_accepted = 0;
  int           burst_left = 1;
  int           gap_left = 0;
  int           long_hold_left = 0;
  bit           long_hold_done = 1'b0;
  int unsigned  rx_cycle = 0;
  rx_mode_t     rx_mode = RX_OPEN;
  int           cycles = 0;

  // One refresh tick: load goal, turn at the bounds in flash mode, step, compare.
  function automatic duty_result_t ramp_tick(tick_t t);
    duty_result_t       r;
    logic [LEVEL_W-1:0] span;
    int unsigned        divisor;
    int unsigned        step;
    if (t.load) goal_level = t.level;
    if (cfg_flash) begin
      if (cur_level <= cfg_min) goal_level = cfg_max;
      else if (cur_level >= cfg_max) goal_level = cfg_min;
    end
    span    = (cfg_max > cfg_min) ? cfg_max - cfg_min : '0;
    divisor = (cfg_fade == 0) ? 1 : cfg_fade;
    step    = (int'(span) * int'(cfg_period)) / divisor;
    if (step < STEP_FLOOR) step = STEP_FLOOR;
    if (step > STEP_CEIL) step = STEP_CEIL;
    // a step that would pass the goal lands on it
    if (cur_level < goal_level) begin
      cur_level = (int'(goal_level) - int'(cur_level) <= step) ? goal_level
                : LEVEL_W'(int'(cur_level) + step);
    end else if (cur_level > goal_level) begin
      cur_level = (int'(cur_level) - int'(goal_level) <= step) ? goal_level
                : LEVEL_W'(int'(cur_level) - step);
    end
    r.duty        = cur_level;
    r.changed     = (cur_level != applied_level);
    applied_level = cur_level;
    return r;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FLASH_MODE:     cfg_flash  = data[0];
      REG_MIN_LEVEL:      cfg_min    = data[LEVEL_W-1:0];
      REG_MAX_LEVEL:      cfg_max    = data[LEVEL_W-1:0];
      REG_REFRESH_PERIOD: cfg_period = data;
      REG_FADE_TIME:      cfg_fade   = data;
      default: ;  // unknown index: the block drops the write
    endcase
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle limit: end the run if results stop coming.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Tick driver: bursts of random length, random gaps, hold data until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        duty_expected.push_back(ramp_tick(offered));
        ticks_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || tick_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          offered = tick_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= offered.level;
          in_tuser  <= offered.load;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            // a quarter of the bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Result receiver: rotating stall patterns, plus one long hold-off while
  // ticks keep coming so the output register fills and the input stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (!long_hold_done && ticks_accepted >= 600 && tick_queue.size() > 20) begin
        long_hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (rx_cycle % 512 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
          default:   out_tready <= rx_cycle[3];
        endcase
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    duty_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (duty_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual duty=%0d changed=%0b",
                 $time, out_tdata, out_tuser);
      end else begin
        want = duty_expected.pop_front();
        if (out_tdata !== want.duty) begin
          errors++;
          $display("%0t: duty mismatch, expected %0d, actual %0d",
                   $time, want.duty, out_tdata);
        end
        if (out_tuser !== want.changed) begin
          errors++;
          $display("%0t: duty_changed mismatch, expected %0b, actual %0b",
                   $time, want.changed, out_tuser);
        end
      end
    end
  end

  // Write one register; call right after a rising edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Write every register, plus one write to an unused index that must be dropped.
  task automatic load_config(logic flash, logic [LEVEL_W-1:0] lo, logic [LEVEL_W-1:0] hi,
                             logic [PERIOD_W-1:0] period, logic [PERIOD_W-1:0] fade);
    write_reg(REG_FLASH_MODE, CFG_DATA_W'(flash));
    write_reg(REG_MIN_LEVEL, CFG_DATA_W'(lo));
    write_reg(REG_MAX_LEVEL, CFG_DATA_W'(hi));
    write_reg(REG_REFRESH_PERIOD, period);
    write_reg(REG_FADE_TIME, fade);
    write_reg(CFG_IDX_W'($urandom_range(REG_FADE_TIME + 1, 7)), CFG_DATA_W'($urandom));
  endtask

  // Hold off until every queued tick is sent and every result has come back.
  task automatic drain;
    while (tick_queue.size() != 0 || in_tvalid || duty_expected.size() != 0)
      @(posedge clk);
  endtask

  task automatic push_tick(logic load, logic [LEVEL_W-1:0] level);
    tick_queue.push_back('{load: load, level: level});
  endtask

  function automatic logic [LEVEL_W-1:0] pick_level;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return LEVEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int n;
    int random_ticks;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] fade;
    random_ticks = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, step 5: ramp up, ignored target, turn down, snap to 12, back down.
    push_tick(1'b1, 8'd255);
    push_tick(1'b1, 8'd255);
    push_tick(1'b1, 8'd255);
    push_tick(1'b0, 8'hAA);
    push_tick(1'b1, 8'd12);
    push_tick(1'b1, 8'd12);
    push_tick(1'b1, 8'd0);
    drain();

    // Max below min gives zero span; zero fade time acts as one: step 1.
    load_config(1'b0, 8'd255, 8'd0, 16'hFFFF, 16'd0);
    push_tick(1'b1, 8'd255);
    push_tick(1'b1, 8'd255);
    push_tick(1'b1, 8'd0);
    drain();

    // Full span over zero fade time saturates the step at 255.
    load_config(1'b0, 8'd0, 8'd255, 16'hFFFF, 16'd0);
    push_tick(1'b1, 8'd255);
    push_tick(1'b1, 8'd0);
    push_tick(1'b1, 8'd128);
    drain();

    // Flash between 10 and 200 with step 19; a load while away from both bounds.
    load_config(1'b1, 8'd10, 8'd200, 16'd100, 16'd1000);
    push_tick(1'b0, 8'd0);
    push_tick(1'b0, 8'd0);
    push_tick(1'b1, 8'd77);
    push_tick(1'b0, 8'd0);
    push_tick(1'b0, 8'd0);
    drain();

    // Flash with min equal to max, zero refresh period.
    load_config(1'b1, 8'd100, 8'd100, 16'd0, 16'hFFFF);
    push_tick(1'b0, 8'd0);
    push_tick(1'b1, 8'd255);
    push_tick(1'b0, 8'd0);
    drain();

    // Random phases: fresh settings, a batch of ticks, then drain before the next write.
    while (random_ticks < RANDOM_TICKS) begin
      case ($urandom_range(0, 5))
        0:       period = '0;
        1:       period = '1;
        2:       period = 16'd1;
        3, 4:    period = PERIOD_W'($urandom_range(1, 200));
        default: period = PERIOD_W'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 5))
        0:       fade = '0;
        1:       fade = '1;
        2:       fade = PERIOD_W'($urandom_range(1, 100));
        3, 4:    fade = PERIOD_W'($urandom_range(100, 5000));
        default: fade = PERIOD_W'($urandom_range(0, 65535));
      endcase
      load_config(1'($urandom_range(0, 1)), pick_level(), pick_level(), period, fade);
      n = $urandom_range(40, 250);
      repeat (n) begin
        push_tick(cfg_flash ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 3) != 0),
                  pick_level());
      end
      random_ticks += n;
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && duty_expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
